// ===== hw/rtl/event_interrupt_controller_irl_unit_assert.svh =====
// Assertion macros for the checker file of the interrupt level unit.
// No dependencies; include by bare file name where assertions are written.
`ifndef EVENT_INTERRUPT_CONTROLLER_IRL_UNIT_ASSERT_SVH
`define EVENT_INTERRUPT_CONTROLLER_IRL_UNIT_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define EICIRL_ASSERT_ON(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) \
        else $error(msg);

// Concurrent assertion on the usual clk and rst_n of the enclosing scope.
`define EICIRL_ASSERT(label, prop, msg) \
    `EICIRL_ASSERT_ON(label, clk, rst_n, prop, msg)

`endif

// ===== hw/rtl/eicirl_pkg.sv =====
// Package of the event interrupt level unit: transfer types, register map
// constants and level codes. No dependencies.
`default_nettype none

package eicirl_pkg;

    localparam int WORD_W           = 32;
    localparam int NUM_STATUS_WORDS = 3;
    localparam int NUM_MASK_WORDS   = 12;
    localparam int STATUS_BITS      = NUM_STATUS_WORDS * WORD_W;
    localparam int DEF_NUM_EVENTS   = 96;

    // Item kinds
    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Register map, byte offsets
    localparam logic [5:0] STATUS_END = 6'h0c;
    localparam logic [5:0] MASK_BASE  = 6'h10;

    // Mask words paired with status words 0, 1 and 2
    localparam int DIAG_MASK_0 = 0;
    localparam int DIAG_MASK_1 = 5;
    localparam int DIAG_MASK_2 = 10;

    // Level codes
    localparam logic [2:0] IRL_NONE = 3'd0;
    localparam logic [2:0] IRL_HIGH = 3'd2;
    localparam logic [2:0] IRL_MID  = 3'd4;
    localparam logic [2:0] IRL_LOW  = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  event_line;
        logic        event_level;
        logic [5:0]  address;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  irl_code;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/eicirl_regs.sv =====
// Status and mask registers with bus decode and level encoding.
// Depends on eicirl_pkg.
`default_nettype none

module eicirl_regs
    import eicirl_pkg::*;
#(
    parameter int NUM_EVENTS = DEF_NUM_EVENTS
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire req_t item,
    output rsp_t      result
);

    localparam logic [3:0] StatusEndWord = STATUS_END[5:2];
    localparam logic [3:0] MaskBaseWord  = MASK_BASE[5:2];

    logic [NUM_EVENTS-1:0]  status_reg;
    logic [NUM_EVENTS-1:0]  status_next;
    logic [WORD_W-1:0]      mask_reg  [NUM_MASK_WORDS];
    logic [WORD_W-1:0]      mask_next [NUM_MASK_WORDS];

    logic [STATUS_BITS-1:0] status_view;
    logic [STATUS_BITS-1:0] status_view_next;
    logic [STATUS_BITS-1:0] clear_vec;
    logic [NUM_EVENTS-1:0]  set_vec;
    logic [3:0]             word_addr;
    logic [3:0]             mask_idx;
    logic                   hit_status;
    logic                   hit_mask;
    logic                   is_read;
    logic                   is_write;
    logic                   is_event;
    logic [WORD_W-1:0]      rd_word;

    assign word_addr  = item.address[5:2];
    assign mask_idx   = word_addr - MaskBaseWord;
    assign hit_status = (word_addr < StatusEndWord);
    assign hit_mask   = (word_addr >= MaskBaseWord);
    assign is_read    = (item.kind == KIND_READ);
    assign is_write   = (item.kind == KIND_WRITE);
    assign is_event   = (item.kind == KIND_EVENT) && item.event_level;

    // Lines at or above NUM_EVENTS have no storage and never match.
    always_comb
    begin
        for (int i = 0; i < NUM_EVENTS; i++)
        begin
            set_vec[i] = is_event && (item.event_line == 7'(i));
        end
    end

    always_comb
    begin
        clear_vec = '0;
        if (is_write && hit_status)
        begin
            unique case (word_addr[1:0])
                2'd0:    clear_vec[0*WORD_W +: WORD_W] = item.write_data;
                2'd1:    clear_vec[1*WORD_W +: WORD_W] = item.write_data;
                2'd2:    clear_vec[2*WORD_W +: WORD_W] = item.write_data;
                default: clear_vec = '0;
            endcase
        end
    end

    assign status_next = step ? ((status_reg & ~clear_vec[NUM_EVENTS-1:0]) | set_vec)
                              : status_reg;

    always_comb
    begin
        for (int j = 0; j < NUM_MASK_WORDS; j++)
        begin
            mask_next[j] = (step && is_write && hit_mask && (mask_idx == 4'(j)))
                         ? item.write_data : mask_reg[j];
        end
    end

    assign status_view      = STATUS_BITS'(status_reg);
    assign status_view_next = STATUS_BITS'(status_next);

    always_comb
    begin
        rd_word = '0;
        if (is_read && hit_status)
        begin
            unique case (word_addr[1:0])
                2'd0:    rd_word = status_view[0*WORD_W +: WORD_W];
                2'd1:    rd_word = status_view[1*WORD_W +: WORD_W];
                2'd2:    rd_word = status_view[2*WORD_W +: WORD_W];
                default: rd_word = '0;
            endcase
        end
        else if (is_read && hit_mask)
        begin
            rd_word = mask_reg[mask_idx];
        end
    end

    // The code reflects the state as it stands after this item.
    always_comb
    begin
        result.read_data = rd_word;
        priority if (|(status_view_next[0*WORD_W +: WORD_W] & mask_next[DIAG_MASK_0]))
            result.irl_code = IRL_HIGH;
        else if (|(status_view_next[1*WORD_W +: WORD_W] & mask_next[DIAG_MASK_1]))
            result.irl_code = IRL_MID;
        else if (|(status_view_next[2*WORD_W +: WORD_W] & mask_next[DIAG_MASK_2]))
            result.irl_code = IRL_LOW;
        else
            result.irl_code = IRL_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= '0;
            for (int j = 0; j < NUM_MASK_WORDS; j++)
            begin
                mask_reg[j] <= '0;
            end
        end
        else
        begin
            status_reg <= status_next;
            for (int j = 0; j < NUM_MASK_WORDS; j++)
            begin
                mask_reg[j] <= mask_next[j];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/event_interrupt_controller_irl_unit.sv =====
// Top level of the event interrupt level unit: request and response stages.
// Depends on eicirl_pkg and eicirl_regs.
//
// Usage. Requests arrive on req (req_valid / req_stall); each is an event
// pulse, a register read or a register write. Every request produces exactly
// one response transfer on rsp (rsp_valid / rsp_stall), in order, carrying
// the read data (zero unless the request was a read of a mapped word) and
// the encoded interrupt level as it stands after that request.
// A taken request sits in the request register; when it moves on, it is
// executed against the status and mask words, its response is loaded into
// the response register and shown from then on. Throughput is one transfer
// per cycle while rsp is not stalled; a single request register feeds the
// register file, which updates state and forms the response in one pass.
// A request may be taken while a response waits: req_stall rises only when
// both the request register and the response register are full and the
// receiver is stalling rsp. A stalled response holds its value.
// Reset clears all status and mask words to zero and empties both stages;
// no response is shown until a request has been taken.
// Pulses on lines at or above NUM_EVENTS are ignored.
`default_nettype none

module event_interrupt_controller_irl_unit
    import eicirl_pkg::*;
#(
    parameter int NUM_EVENTS = DEF_NUM_EVENTS
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    logic req_valid_reg;
    logic req_valid_next;
    req_t req_reg;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;
    rsp_t result;
    logic advance;
    logic req_take;

    // The held request moves on whenever the response stage is free or
    // is being emptied in this cycle.
    assign advance   = req_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    eicirl_regs #(
        .NUM_EVENTS (NUM_EVENTS)
    ) u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (req_reg),
        .result (result)
    );

    always_comb
    begin
        req_valid_next = req_take ? 1'b1 : (advance ? 1'b0 : req_valid_reg);
        rsp_valid_next = advance ? 1'b1 : (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/eicirl_chk.sv =====
// Port-level checker for the event interrupt level unit, with its bind.
// Depends on eicirl_pkg and the assertion macro header.
`default_nettype none
`include "event_interrupt_controller_irl_unit_assert.svh"

module eicirl_chk
    import eicirl_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    logic req_xfer;
    logic rsp_held;
    logic code_legal;

    assign req_xfer   = req_valid && !req_stall;
    assign rsp_held   = rsp_valid && rsp_stall;
    assign code_legal = (rsp.irl_code == IRL_NONE) || (rsp.irl_code == IRL_HIGH)
                     || (rsp.irl_code == IRL_MID) || (rsp.irl_code == IRL_LOW);

    `EICIRL_ASSERT(a_stall_when_full, req_stall |-> rsp_held, "request stalled, response free")
    `EICIRL_ASSERT(a_code_legal, rsp_valid |-> code_legal, "illegal level code")
    `EICIRL_ASSERT(a_latency, (req_xfer ##1 !rsp_stall) |=> rsp_valid, "response missing")
    `EICIRL_ASSERT(a_rsp_hold, rsp_held |=> rsp_valid, "stalled response dropped")
    `EICIRL_ASSERT(a_rsp_stable, rsp_held |=> $stable(rsp), "stalled response changed")

endmodule

bind event_interrupt_controller_irl_unit eicirl_chk u_eicirl_chk (.*);

`default_nettype wire
